// File: rtl/flow_table_with_aging_assert.svh
// Assertion macros shared by the flow table modules.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef FLOW_TABLE_WITH_AGING_ASSERT_SVH
`define FLOW_TABLE_WITH_AGING_ASSERT_SVH

`ifndef SYNTHESIS

`define FTA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define FTA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FTA_ASSERT(lbl, ante, cons, msg)

`define FTA_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: rtl/fta_pkg.sv
package fta_pkg;

	localparam logic [1:0] REQ_QUERY = 2'd0;
	localparam logic [1:0] REQ_MARK  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;
	localparam logic [1:0] REQ_CLEAR = 2'd3;

	localparam logic [2:0] STAT_DONE      = 3'd0;
	localparam logic [2:0] STAT_INSERTED  = 3'd1;
	localparam logic [2:0] STAT_REFRESHED = 3'd2;
	localparam logic [2:0] STAT_FULL      = 3'd3;
	localparam logic [2:0] STAT_NOT_TCP   = 3'd4;

	localparam logic [15:0] AGE_LIMIT_RESET = 16'd60;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_WRITE,
		S_CLEAR,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		OP_QUERY,
		OP_MARK,
		OP_SIMPLE
	} op_t;

	typedef struct packed {
		logic [63:0] src_hi;
		logic [63:0] src_lo;
		logic [63:0] dst_hi;
		logic [63:0] dst_lo;
		logic [31:0] ports;
	} key_t;

	typedef struct packed {
		logic        valid;
		key_t        key;
		logic [31:0] stamp;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic tick;
		logic clr_live;
		logic scan_rd;
		logic clr_wr;
		logic mark_wr;
		logic rsp_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic cnt_last;
	} sts_t;

endpackage

// File: rtl/fta_ctrl.sv
`include "flow_table_with_aging_assert.svh"

module fta_ctrl
	import fta_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] req_type,
	input  logic       is_tcp,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	input  sts_t       sts,
	output cmd_t       cmd
);

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   rsp_valid_q;
	logic   out_free;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			op_q        <= OP_SIMPLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				// Clearing pass over the table after reset.
				cmd.clr_wr = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					unique case (req_type) inside
						REQ_TICK: begin
							cmd.tick = 1'b1;
							op_d     = OP_SIMPLE;
							state_d  = S_RESP;
						end
						REQ_CLEAR: begin
							cmd.clr_live = 1'b1;
							op_d         = OP_SIMPLE;
							state_d      = S_CLEAR;
						end
						REQ_QUERY, REQ_MARK: begin
							if (!is_tcp) begin
								op_d    = OP_SIMPLE;
								state_d = S_RESP;
							end else begin
								op_d    = (req_type == REQ_MARK) ? OP_MARK : OP_QUERY;
								state_d = S_SCAN;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// The last read word is checked in this cycle.
				state_d = (op_q == OP_MARK) ? S_WRITE : S_RESP;
			end
			S_WRITE: begin
				cmd.mark_wr = 1'b1;
				state_d     = S_RESP;
			end
			S_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.cnt_last) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					cmd.rsp_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`FTA_ASSERT(a_rsp_load_free, cmd.rsp_load, !rsp_valid_q || !rsp_stall, "result overwritten")
	`FTA_ASSERT_NEXT(a_accept_busy, req_valid && !req_stall, state_q != S_IDLE, "idle after accept")
	`FTA_ASSERT(a_mark_op, cmd.mark_wr, op_q == OP_MARK, "table write outside a mark")

endmodule

// File: rtl/fta_dp.sv
`include "flow_table_with_aging_assert.svh"

module fta_dp
	import fta_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic [1:0]  req_type,
	input  logic        is_tcp,
	input  logic        is_ipv6,
	input  logic [63:0] src_addr_hi,
	input  logic [63:0] src_addr_lo,
	input  logic [63:0] dst_addr_hi,
	input  logic [63:0] dst_addr_lo,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic        cfg_valid,
	input  logic [15:0] cfg_data,
	output logic        hit,
	output logic [2:0]  status,
	output logic [8:0]  entry_count,
	output logic [8:0]  expired_count
);

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	entry_t mem [TABLE_ENTRIES];

	logic [15:0]   age_q;
	logic [31:0]   now_q;
	logic [31:0]   last_sweep_q;
	logic [CW-1:0] live_q;
	logic [CW-1:0] expired_q;
	logic [AW-1:0] scan_q;
	logic [AW-1:0] addr_s1;
	logic          rd_vld_s1;
	entry_t        rd_s1;
	logic          sweep_q;
	logic          found_q;
	logic          free_q;
	logic [AW-1:0] found_idx_q;
	logic [AW-1:0] free_idx_q;
	logic [2:0]    mark_status_q;
	logic [1:0]    req_q;
	logic          tcp_q;
	key_t          key_q;

	key_t          in_key;
	logic          sweep_due;
	logic          stale;
	logic          kill;
	logic          alive;
	logic          match;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_word;

	assign sts.cnt_last = (scan_q == LAST_IDX);

	always_comb begin
		in_key.src_hi = is_ipv6 ? src_addr_hi : 64'd0;
		in_key.src_lo = is_ipv6 ? src_addr_lo : {32'd0, src_addr_lo[31:0]};
		in_key.dst_hi = is_ipv6 ? dst_addr_hi : 64'd0;
		in_key.dst_lo = is_ipv6 ? dst_addr_lo : {32'd0, dst_addr_lo[31:0]};
		in_key.ports  = {src_port, dst_port};
	end

	// A query sweeps only once the interval since the last sweep has passed.
	assign sweep_due = (req_type == REQ_QUERY) && is_tcp &&
	                   ((now_q - last_sweep_q) > {16'd0, age_q});

	// Per-word checks on the registered read data of the scan.
	assign stale = (now_q - rd_s1.stamp) > {16'd0, age_q};
	assign kill  = rd_vld_s1 && sweep_q && rd_s1.valid && stale;
	assign alive = rd_s1.valid && !(sweep_q && stale);
	assign match = (rd_s1.key == key_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = scan_q;
		wr_word = '0;
		if (cmd.clr_wr) begin
			wr_en = 1'b1;
		end else if (kill) begin
			wr_en         = 1'b1;
			wr_addr       = addr_s1;
			wr_word       = rd_s1;
			wr_word.valid = 1'b0;
		end else if (cmd.mark_wr && (found_q || free_q)) begin
			wr_en         = 1'b1;
			wr_addr       = found_q ? found_idx_q : free_idx_q;
			wr_word.valid = 1'b1;
			wr_word.key   = key_q;
			wr_word.stamp = now_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		if (cmd.scan_rd) begin
			rd_s1 <= mem[scan_q];
		end
		addr_s1 <= scan_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q         <= AGE_LIMIT_RESET;
			now_q         <= '0;
			last_sweep_q  <= '0;
			live_q        <= '0;
			expired_q     <= '0;
			scan_q        <= '0;
			rd_vld_s1     <= 1'b0;
			sweep_q       <= 1'b0;
			found_q       <= 1'b0;
			free_q        <= 1'b0;
			mark_status_q <= STAT_DONE;
			req_q         <= REQ_TICK;
			tcp_q         <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cfg_valid) begin
				age_q <= cfg_data;
			end
			if (cmd.tick) begin
				now_q <= now_q + 32'd1;
			end
			if (cmd.scan_rd || cmd.clr_wr) begin
				scan_q <= (scan_q == LAST_IDX) ? '0 : scan_q + AW'(1);
			end
			if (cmd.load) begin
				req_q     <= req_type;
				tcp_q     <= is_tcp;
				found_q   <= 1'b0;
				free_q    <= 1'b0;
				expired_q <= '0;
				sweep_q   <= sweep_due;
				if (sweep_due) begin
					last_sweep_q <= now_q;
				end
			end
			if (cmd.clr_live) begin
				live_q <= '0;
			end else if (kill) begin
				live_q <= live_q - CW'(1);
			end else if (cmd.mark_wr && !found_q && free_q) begin
				live_q <= live_q + CW'(1);
			end
			if (kill) begin
				expired_q <= expired_q + CW'(1);
			end
			if (rd_vld_s1) begin
				if (alive && match && !found_q) begin
					found_q <= 1'b1;
				end
				if (!rd_s1.valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.mark_wr) begin
				if (found_q) begin
					mark_status_q <= STAT_REFRESHED;
				end else if (free_q) begin
					mark_status_q <= STAT_INSERTED;
				end else begin
					mark_status_q <= STAT_FULL;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= in_key;
		end
		if (rd_vld_s1 && alive && match && !found_q) begin
			found_idx_q <= addr_s1;
		end
		if (rd_vld_s1 && !rd_s1.valid && !free_q) begin
			free_idx_q <= addr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			hit           <= (req_q == REQ_QUERY) && tcp_q && found_q;
			entry_count   <= 9'(live_q);
			expired_count <= 9'(expired_q);
			if ((req_q == REQ_QUERY || req_q == REQ_MARK) && !tcp_q) begin
				status <= STAT_NOT_TCP;
			end else if (req_q == REQ_MARK) begin
				status <= mark_status_q;
			end else begin
				status <= STAT_DONE;
			end
		end
	end

	`FTA_ASSERT(a_live_max, 1'b1, live_q <= CW'(TABLE_ENTRIES), "entry count above table size")
	`FTA_ASSERT(a_insert_room, cmd.mark_wr && !found_q && free_q, live_q < CW'(TABLE_ENTRIES), "insert into full table")
	`FTA_ASSERT(a_clear_no_scan, cmd.clr_wr, !rd_vld_s1, "clear overlaps a scan")

endmodule

// File: rtl/flow_table_with_aging.sv
// Connection table with aging. Each word on the request channel is a query, a mark, a
// one-second tick or a clear, and each gives exactly one result word. A query or a mark
// of a TCP packet scans every table entry once, reading the table memory, and checks
// the last read word after the scan; a mark then also makes its table write. A clear
// writes every entry once. A tick or a non-TCP word goes straight to its result.
// A new request is accepted in the cycle after a result is loaded into the output
// register, even while that result is still stalled. After reset the table is cleared
// before the first request is accepted. The user must write age_limit_secs through the
// cfg channel only while the block is idle; the block itself does not enforce this.
module flow_table_with_aging
	import fta_pkg::*;
#(
	parameter int TABLE_ENTRIES = 256
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic        is_tcp,
	input  logic        is_ipv6,
	input  logic [63:0] src_addr_hi,
	input  logic [63:0] src_addr_lo,
	input  logic [63:0] dst_addr_hi,
	input  logic [63:0] dst_addr_lo,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        hit,
	output logic [2:0]  status,
	output logic [8:0]  entry_count,
	output logic [8:0]  expired_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.is_tcp    (is_tcp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	fta_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.req_type      (req_type),
		.is_tcp        (is_tcp),
		.is_ipv6       (is_ipv6),
		.src_addr_hi   (src_addr_hi),
		.src_addr_lo   (src_addr_lo),
		.dst_addr_hi   (dst_addr_hi),
		.dst_addr_lo   (dst_addr_lo),
		.src_port      (src_port),
		.dst_port      (dst_port),
		.cfg_valid     (cfg_valid & cfg_ready),
		.cfg_data      (cfg_data),
		.hit           (hit),
		.status        (status),
		.entry_count   (entry_count),
		.expired_count (expired_count)
	);

endmodule
